FILE: rtl/core/iwdp_pkg.sv
// Shared types, widths and constants for the int8 weight dot product block.
package iwdp_pkg;

    localparam int ACT_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int LANES     = 4;
    localparam int WORD_W    = LANES * BYTE_W;
    localparam int SCALE_W   = 16;
    localparam int BIAS_W    = 32;
    localparam int PROD_W    = ACT_W + BYTE_W;
    localparam int ACC_W     = 40;
    localparam int SPLIT_W   = 20;
    localparam int PLO_W     = SPLIT_W + 1 + SCALE_W;
    localparam int PHI_W     = (ACC_W - SPLIT_W) + SCALE_W;
    localparam int FULL_W    = ACC_W + SCALE_W + 1;
    localparam int SHIFT     = 14;
    localparam int SHR_W     = FULL_W - SHIFT;
    localparam int RES_W     = SHR_W + 1;
    localparam int OUT_W     = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic acc_add;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } stat_t;

endpackage

FILE: rtl/core/iwdp_in_if.sv
// Input channel carrying activations, packed weights, scale, bias and end markers.
interface iwdp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] act0;
    logic signed [15:0] act1;
    logic signed [15:0] act2;
    logic signed [15:0] act3;
    logic        [31:0] weight_word;
    logic signed [15:0] scale;
    logic signed [31:0] bias_value;
    logic               last_word;
    logic               last_col;
    logic               last_row;

    modport source (
        output valid, act0, act1, act2, act3, weight_word, scale, bias_value,
               last_word, last_col, last_row,
        input  ready
    );

    modport sink (
        input  valid, act0, act1, act2, act3, weight_word, scale, bias_value,
               last_word, last_col, last_row,
        output ready
    );
endinterface

FILE: rtl/core/iwdp_out_if.sv
// Output channel carrying the scaled dot product, its saturation flag and end markers.
interface iwdp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] dot_result;
    logic               saturated;
    logic               col_end;
    logic               row_end;

    modport source (
        output valid, dot_result, saturated, col_end, row_end,
        input  ready
    );

    modport sink (
        input  valid, dot_result, saturated, col_end, row_end,
        output ready
    );
endinterface

FILE: rtl/core/iwdp_ctrl.sv
// Sequencer that steps the datapath through accumulate, scale and output phases.
module iwdp_ctrl
    import iwdp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                state_next = stat.last ? S_MUL_LO : S_IDLE;
            end
            S_MUL_LO:
            begin
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
            end
            S_SUM:
            begin
                cmd.sum = 1'b1;
            end
            S_OUT:
            begin
                cmd.out_load = !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/iwdp_datapath.sv
// Multiply-accumulate, split scale multiply, bias add, saturation and output register.
module iwdp_datapath
    import iwdp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    input  logic signed [ACT_W-1:0]   act0,
    input  logic signed [ACT_W-1:0]   act1,
    input  logic signed [ACT_W-1:0]   act2,
    input  logic signed [ACT_W-1:0]   act3,
    input  logic        [WORD_W-1:0]  weight_word,
    input  logic signed [SCALE_W-1:0] scale,
    input  logic signed [BIAS_W-1:0]  bias_value,
    input  logic                      last_word,
    input  logic                      last_col,
    input  logic                      last_row,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [OUT_W-1:0]   dot_result,
    output logic                      saturated,
    output logic                      col_end,
    output logic                      row_end
);

    logic signed [ACT_W-1:0]   act_w [LANES];
    logic signed [PROD_W-1:0]  prod_reg [LANES];
    logic signed [PROD_W-1:0]  prod_next [LANES];
    logic signed [SCALE_W-1:0] scale_reg;
    logic signed [BIAS_W-1:0]  bias_reg;
    logic                      last_reg;
    logic                      col_reg;
    logic                      row_reg;

    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   sum_next;
    logic signed [ACC_W-1:0]   total_reg;
    logic signed [PLO_W-1:0]   plo_reg;
    logic signed [PLO_W-1:0]   plo_next;
    logic signed [PHI_W-1:0]   phi_reg;
    logic signed [PHI_W-1:0]   phi_next;
    logic signed [FULL_W-1:0]  full_reg;
    logic signed [FULL_W-1:0]  full_next;
    logic signed [RES_W-1:0]   res_next;
    logic                      sat_next;
    logic signed [OUT_W-1:0]   dot_next;

    logic                      out_valid_reg;
    logic signed [OUT_W-1:0]   dot_reg;
    logic                      sat_reg;
    logic                      col_out_reg;
    logic                      row_out_reg;

    assign act_w[0] = act0;
    assign act_w[1] = act1;
    assign act_w[2] = act2;
    assign act_w[3] = act3;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod_next[i] = act_w[i] * $signed(weight_word[i*BYTE_W +: BYTE_W]);
        end
    end

    always_comb
    begin
        sum_next = acc_reg;
        for (int i = 0; i < LANES; i++)
        begin
            sum_next = sum_next
                + {{(ACC_W-PROD_W){prod_reg[i][PROD_W-1]}}, prod_reg[i]};
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_add)
        begin
            acc_next = last_reg ? '0 : sum_next;
        end
    end

    // The total is split into a signed upper half and an unsigned lower half.
    assign plo_next = $signed({1'b0, total_reg[SPLIT_W-1:0]}) * scale_reg;
    assign phi_next = $signed(total_reg[ACC_W-1:SPLIT_W]) * scale_reg;
    assign full_next = {phi_reg[PHI_W-1], phi_reg, {SPLIT_W{1'b0}}}
        + {{(FULL_W-PLO_W){plo_reg[PLO_W-1]}}, plo_reg};

    always_comb
    begin
        res_next = {full_reg[FULL_W-1], full_reg[FULL_W-1:SHIFT]}
            + {{(RES_W-BIAS_W){bias_reg[BIAS_W-1]}}, bias_reg};
        sat_next = (res_next[RES_W-1:OUT_W-1] != '0)
            && (res_next[RES_W-1:OUT_W-1] != '1);
        if (sat_next)
        begin
            dot_next = res_next[RES_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                         : {1'b0, {(OUT_W-1){1'b1}}};
        end
        else
        begin
            dot_next = res_next[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            scale_reg <= scale;
            bias_reg  <= bias_value;
            last_reg  <= last_word;
            col_reg   <= last_col;
            row_reg   <= last_row;
        end
        if (cmd.acc_add)
        begin
            total_reg <= sum_next;
        end
        if (cmd.mul_lo)
        begin
            plo_reg <= plo_next;
        end
        if (cmd.mul_hi)
        begin
            phi_reg <= phi_next;
        end
        if (cmd.sum)
        begin
            full_reg <= full_next;
        end
        if (cmd.out_load)
        begin
            dot_reg     <= dot_next;
            sat_reg     <= sat_next;
            col_out_reg <= col_reg;
            row_out_reg <= row_reg;
        end
    end

    assign stat.last     = last_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign dot_result = dot_reg;
    assign saturated  = sat_reg;
    assign col_end    = col_out_reg;
    assign row_end    = row_out_reg;

    // A final word must leave the accumulator empty for the next dot product.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_add && last_reg |=> acc_reg == '0)
        else $error("accumulator not cleared after final word");

    // A new result must never overwrite one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

FILE: rtl/core/int8_weight_dot_product.sv
// Top level of the int8 weight dot product block.
//
// Items arrive on din: four signed Q8.8 activations, a word of four signed
// int8 weights with byte 0 lowest, a Q2.14 scale, a Q24.8 bias and three
// end markers. Each item's four products are added into a 40-bit
// accumulator. On an item with last_word set, the total is multiplied by
// the scale, shifted right by 14 with floor rounding, added to the bias and
// saturated to 32 bits; one result item then appears on dout and the
// accumulator is cleared. Items without last_word give no result.
// For an item that is not a last word, din.ready drops after it is accepted
// while the accumulate step runs. A last word runs the accumulate step, the
// low and high scale multiply steps, a sum step and an output step that adds
// the bias and saturates; its result shows on dout in the same cycle that din
// is ready again. The scale multiply is done as two 20-bit halves on one
// sequencer.
// After reset the accumulator is zero and no result is pending.
// A result waits in the output register while dout.ready is low; a further
// last word then holds in its output step until the register is free.
module int8_weight_dot_product
    import iwdp_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    iwdp_in_if.sink    din,
    iwdp_out_if.source dout
);

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    assign din.ready = in_ready;

    iwdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iwdp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .act0        (din.act0),
        .act1        (din.act1),
        .act2        (din.act2),
        .act3        (din.act3),
        .weight_word (din.weight_word),
        .scale       (din.scale),
        .bias_value  (din.bias_value),
        .last_word   (din.last_word),
        .last_col    (din.last_col),
        .last_row    (din.last_row),
        .out_valid   (dout.valid),
        .out_ready   (dout.ready),
        .dot_result  (dout.dot_result),
        .saturated   (dout.saturated),
        .col_end     (dout.col_end),
        .row_end     (dout.row_end)
    );

endmodule
